[rtl/wsbm_pkg.sv]
// ----------------------------------------------------------------------------
// wsbm_pkg
// Shared types and constants for the wildcard substring best-match unit.
// ----------------------------------------------------------------------------
package wsbm_pkg;

  localparam int BYTE_W  = 8;
  localparam int ID_W    = 16;
  localparam int SIZE_W  = 8;
  localparam int REG_W   = 64;
  localparam int PLEN_W  = 5;
  localparam int ADDR_W  = 2;
  localparam int PAT_W   = 2 * REG_W;
  localparam int PAT_BYTES = PAT_W / BYTE_W;

  localparam logic [BYTE_W-1:0] WILD_QUESTION = 8'h3F;
  localparam logic [BYTE_W-1:0] WILD_HASH     = 8'h23;

  localparam logic [PLEN_W-1:0] PLEN_RESET = 5'd1;

  typedef enum logic [ADDR_W-1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_PAT_LEN  = 2'd2
  } cfg_addr_t;

  // Record attributes and markers handed to the best-match tracker.
  typedef struct packed {
    logic              matched;
    logic              enabled;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   id;
    logic              end_rec;
    logic              end_tab;
  } rec_info_t;

endpackage

[rtl/wsbm_window_match.sv]
// ----------------------------------------------------------------------------
// wsbm_window_match
// Byte window of the current record and parallel wildcard pattern compare.
// ----------------------------------------------------------------------------
module wsbm_window_match import wsbm_pkg::*; #(
  parameter int PATTERN_MAX = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              end_rec,
  input  logic [PAT_W-1:0]  pattern,
  input  logic [PLEN_W-1:0] pat_len,
  output logic              hit
);

  localparam int CNT_W = $clog2(PATTERN_MAX + 1);
  localparam int LEN_W = (CNT_W > PLEN_W) ? CNT_W : PLEN_W;
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PATTERN_MAX);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(PATTERN_MAX);

  logic [BYTE_W-1:0] win_r   [PATTERN_MAX];
  logic [BYTE_W-1:0] win_nxt [PATTERN_MAX];
  logic [BYTE_W-1:0] pat_b   [PATTERN_MAX];
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic              matched_r;
  logic [LEN_W-1:0]  len_ext, len_eff;
  logic [PATTERN_MAX-1:0] pos_ok;
  logic              win_hit;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pat
    if (i < PAT_BYTES) begin : g_in
      assign pat_b[i] = pattern[i*BYTE_W +: BYTE_W];
    end else begin : g_zero
      assign pat_b[i] = '0;
    end
  end

  always_comb begin
    win_nxt[0] = text_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  assign seen_nxt = (seen_r == MAX_CNT) ? seen_r : seen_r + CNT_W'(1);
  assign len_ext  = LEN_W'(pat_len);
  assign len_eff  = (len_ext > MAX_LEN) ? MAX_LEN : len_ext;

  // window position j is compared against pattern byte len-1-j
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pos
    logic [LEN_W-1:0]  pidx;
    logic [BYTE_W-1:0] pb;
    assign pidx = len_eff - LEN_W'(j + 1);
    assign pb   = pat_b[pidx[IDX_W-1:0]];
    assign pos_ok[j] = (LEN_W'(j) >= len_eff) || (pb == WILD_QUESTION) ||
                       (pb == WILD_HASH) || (pb == win_nxt[j]);
  end

  assign win_hit = (LEN_W'(seen_nxt) >= len_eff) && (&pos_ok);
  assign hit     = matched_r || win_hit;

  always_ff @(posedge clk) begin
    if (step) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      matched_r <= 1'b0;
    end else if (step) begin
      if (end_rec) begin
        seen_r    <= '0;
        matched_r <= 1'b0;
      end else begin
        seen_r    <= seen_nxt;
        matched_r <= hit;
      end
    end
  end

endmodule

[rtl/wsbm_best_select.sv]
// ----------------------------------------------------------------------------
// wsbm_best_select
// Keeps the smallest matching enabled record and holds the result word.
// ----------------------------------------------------------------------------
module wsbm_best_select import wsbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  rec_info_t         info,
  input  logic              res_ready,
  output logic              res_valid,
  output logic              res_found,
  output logic [ID_W-1:0]   res_id,
  output logic [SIZE_W-1:0] res_size
);

  logic              have_r;
  logic [ID_W-1:0]   best_id_r;
  logic [SIZE_W-1:0] best_size_r;
  logic              upd, b_have;
  logic [ID_W-1:0]   b_id;
  logic [SIZE_W-1:0] b_size;
  logic              valid_r, found_r;
  logic [ID_W-1:0]   id_r;
  logic [SIZE_W-1:0] size_r;

  assign upd    = info.end_rec && info.matched && info.enabled &&
                  (!have_r || (info.size < best_size_r));
  assign b_have = upd || have_r;
  assign b_id   = upd ? info.id   : best_id_r;
  assign b_size = upd ? info.size : best_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (step && info.end_rec) begin
      have_r <= b_have && !info.end_tab;
    end
  end

  always_ff @(posedge clk) begin
    if (step && info.end_rec) begin
      best_id_r   <= b_id;
      best_size_r <= b_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step && info.end_tab) begin
      valid_r <= 1'b1;
    end else if (res_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && info.end_tab) begin
      found_r <= b_have;
      id_r    <= b_have ? b_id   : '0;
      size_r  <= b_have ? b_size : '0;
    end
  end

  assign res_valid = valid_r;
  assign res_found = found_r;
  assign res_id    = id_r;
  assign res_size  = size_r;

endmodule

[rtl/wildcard_substring_best_match_unit.sv]
// ----------------------------------------------------------------------------
// wildcard_substring_best_match_unit
// Wildcard substring search over a table of records; reports the smallest
// enabled record whose text contains the configured pattern.
// ----------------------------------------------------------------------------
//  port group | dir | tdata (low bit up)                         | side bits
//  in_        | in  | text_byte, record_id, record_size,         | tuser: last_of_record
//             |     | record_enabled, 7 zero bits                | tlast: last_of_table
//  out_       | out | best_record, best_size                     | tuser: found
//  cfg_       | in  | write enable, 2-bit index, 64-bit data     | -
//
//  One byte per cycle unless stalled: a byte is taken into the input register,
//  and the window compare and best-record update are registered from that register.
//  The result register is loaded when the table's last byte leaves the input register.
//  Synchronous active-low reset clears control state; no clearing pass.
//  Input stalls only on a table end while the result register is still held.
// ----------------------------------------------------------------------------
module wildcard_substring_best_match_unit import wsbm_pkg::*; #(
  parameter int PATTERN_MAX = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // text_byte, record_id, record_size, record_enabled
  input  logic              in_tuser,   // last_of_record
  input  logic              in_tlast,   // last_of_table
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // best_record, best_size
  output logic              out_tuser,  // found
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]  cfg_wdata
);

  logic [REG_W-1:0]  pat_low_r, pat_high_r;
  logic [PLEN_W-1:0] pat_len_r;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_text_r;
  logic [ID_W-1:0]   s1_id_r;
  logic [SIZE_W-1:0] s1_size_r;
  logic              s1_en_r, s1_lrec_r, s1_ltab_r;
  logic              s1_go, in_take, out_free, hit;
  rec_info_t         info;
  logic              res_found;
  logic [ID_W-1:0]   res_id;
  logic [SIZE_W-1:0] res_size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= PLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr_t'(cfg_addr))
        CFG_PAT_LOW:  pat_low_r  <= cfg_wdata;
        CFG_PAT_HIGH: pat_high_r <= cfg_wdata;
        CFG_PAT_LEN:  pat_len_r  <= cfg_wdata[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free  = !out_tvalid || out_tready;
  assign s1_go     = s1_valid_r && (!s1_ltab_r || out_free);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_text_r <= in_tdata[7:0];
      s1_id_r   <= in_tdata[23:8];
      s1_size_r <= in_tdata[31:24];
      s1_en_r   <= in_tdata[32];
      s1_lrec_r <= in_tuser;
      s1_ltab_r <= in_tlast;
    end
  end

  wsbm_window_match #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .text_byte (s1_text_r),
    .end_rec   (s1_lrec_r || s1_ltab_r),
    .pattern   ({pat_high_r, pat_low_r}),
    .pat_len   (pat_len_r),
    .hit       (hit)
  );

  assign info.matched = hit;
  assign info.enabled = s1_en_r;
  assign info.size    = s1_size_r;
  assign info.id      = s1_id_r;
  assign info.end_rec = s1_lrec_r || s1_ltab_r;
  assign info.end_tab = s1_ltab_r;

  wsbm_best_select u_best (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .info      (info),
    .res_ready (out_tready),
    .res_valid (out_tvalid),
    .res_found (res_found),
    .res_id    (res_id),
    .res_size  (res_size)
  );

  assign out_tdata = {res_size, res_id};
  assign out_tuser = res_found;

endmodule
